// File: rtl/gnt_pkg.sv
package gnt_pkg;

    localparam logic [2:0] OP_LOAD_GRAD = 3'd0;
    localparam logic [2:0] OP_LOAD_PX   = 3'd1;
    localparam logic [2:0] OP_LOAD_PY   = 3'd2;
    localparam logic [2:0] OP_LOAD_PZ   = 3'd3;
    localparam logic [2:0] OP_EVAL      = 3'd4;

    localparam logic [0:0] REG_OCTAVES = 1'b0;
    localparam logic [0:0] REG_MODE    = 1'b1;

    typedef struct packed {
        logic start_octave;
        logic start_corner;
        logic corner_step;
        logic corner_last;
        logic octave_done;
        logic finish;
        logic abs_result;
    } gnt_cmd_t;

    typedef struct packed {
        logic corner_final;
        logic pipe_empty;
    } gnt_sts_t;

endpackage

// File: rtl/gnt_ctrl.sv
module gnt_ctrl
    import gnt_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [2:0]          op,
    output logic                in_stall,
    input  logic                out_valid,
    input  logic [3:0]          octave_count,
    input  logic                turbulence_mode,
    input  gnt_sts_t            sts,
    output gnt_cmd_t            cmd,
    output logic [4:0]          octave_idx
);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SETUP  = 5'b00010,
        ST_CORNER = 5'b00100,
        ST_DRAIN  = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] oct_reg, oct_next;
    logic [4:0] total_reg, total_next;
    logic [4:0] n_oct;

    always_comb
    begin
        if (!turbulence_mode)
            n_oct = 5'd1;
        else if ({1'b0, octave_count} > 5'(MAX_OCTAVES))
            n_oct = 5'(MAX_OCTAVES);
        else
            n_oct = {1'b0, octave_count};
    end

    assign in_stall   = (state_reg != ST_IDLE) || out_valid;
    assign octave_idx = oct_reg;

    always_comb
    begin
        state_next = state_reg;
        oct_next   = oct_reg;
        total_next = total_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall && op == OP_EVAL)
                begin
                    oct_next   = '0;
                    total_next = n_oct;
                    cmd.start_octave = 1'b1;
                    state_next = (n_oct == 5'd0) ? ST_DONE : ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                cmd.start_corner = 1'b1;
                state_next = ST_CORNER;
            end
            ST_CORNER:
            begin
                cmd.corner_step = 1'b1;
                if (sts.corner_final)
                begin
                    cmd.corner_last = 1'b1;
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (sts.pipe_empty)
                begin
                    cmd.octave_done = 1'b1;
                    oct_next = oct_reg + 5'd1;
                    state_next = (oct_reg + 5'd1 == total_reg) ? ST_DONE : ST_SETUP;
                end
            end
            ST_DONE:
            begin
                cmd.finish = 1'b1;
                cmd.abs_result = turbulence_mode;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            oct_reg   <= '0;
            total_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            oct_reg   <= oct_next;
            total_reg <= total_next;
        end
    end

endmodule

// File: rtl/gnt_datapath.sv
module gnt_datapath
    import gnt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load_en,
    input  logic [2:0]         op,
    input  logic [7:0]         entry_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    input  logic [7:0]         perm_entry,
    input  logic [31:0]        pos_x,
    input  logic [31:0]        pos_y,
    input  logic [31:0]        pos_z,
    input  gnt_cmd_t           cmd,
    input  logic [4:0]         octave_idx,
    output gnt_sts_t           sts,
    output logic [31:0]        result
);

    localparam int F = 16;
    localparam logic [F:0] ONE = 17'(1) << F;

    logic [47:0] grad_mem [256];
    logic [7:0]  px_mem [256];
    logic [7:0]  py_mem [256];
    logic [7:0]  pz_mem [256];

    logic [31:0] px_reg, py_reg, pz_reg;
    logic [F:0]  fx_reg, fy_reg, fz_reg;
    logic [F:0]  dx_reg, dy_reg, dz_reg;
    logic [2:0]  corner_reg;
    logic        issue_reg;
    logic [47:0] acc_reg;
    logic [47:0] oct_acc_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            unique case (op)
                OP_LOAD_GRAD: grad_mem[entry_index] <= {grad_x, grad_y, grad_z};
                OP_LOAD_PX:   px_mem[entry_index] <= perm_entry;
                OP_LOAD_PY:   py_mem[entry_index] <= perm_entry;
                OP_LOAD_PZ:   pz_mem[entry_index] <= perm_entry;
                default: ;
            endcase
        end
    end

    // fade in two multiply steps per axis, done in the setup cycle and stage 1
    function automatic logic [F:0] fade_f(input logic [F-1:0] u, input logic [F:0] u2);
        logic [F+2:0] lin;
        logic [2*F+3:0] pr;
        begin
            lin = (19'(3) << F) - (19'(u) << 1);
            pr  = 36'(u2) * 36'(lin);
            fade_f = 17'(pr >> F);
        end
    endfunction

    logic [F:0] u2x_reg, u2y_reg, u2z_reg;
    logic [F-1:0] ux_reg, uy_reg, uz_reg;
    logic       fade_pend_reg;

    // stage registers
    logic        s1_v, s2_v, s3_v, s4_v;
    logic [2:0]  s1_c;
    logic [7:0]  s1_hx, s1_hy, s1_hz;
    logic [7:0]  s2_h;
    logic [2:0]  s2_c, s3_c;
    logic [47:0] s3_g;
    logic [F:0]  s3_wxy;
    logic signed [33:0] s4_dot;
    logic [F:0]  s4_wt;
    logic signed [47:0] s5_prod;
    logic        s5_v;

    logic [7:0] cx, cy, cz;
    assign cx = px_reg[F+7:F] + 8'(corner_reg[2]);
    assign cy = py_reg[F+7:F] + 8'(corner_reg[1]);
    assign cz = pz_reg[F+7:F] + 8'(corner_reg[0]);

    function automatic logic [F:0] wsel(input logic b, input logic [F:0] d);
        wsel = b ? d : ONE - d;
    endfunction

    function automatic logic signed [F+1:0] osel(input logic b, input logic [F:0] f);
        osel = b ? $signed({1'b0, f}) - $signed({1'b0, ONE}) : $signed({1'b0, f});
    endfunction

    logic [2*F+1:0] wxy_full;
    logic [2*F+1:0] wt_full;
    logic signed [33:0] gxo, gyo, gzo;
    logic signed [35:0] dsum;
    logic signed [50:0] prod_full;

    always_comb
    begin
        wxy_full  = 34'(wsel(s2_c[2], dx_reg)) * 34'(wsel(s2_c[1], dy_reg));
        gxo = $signed(s3_g[47:32]) * osel(s3_c[2], fx_reg);
        gyo = $signed(s3_g[31:16]) * osel(s3_c[1], fy_reg);
        gzo = $signed(s3_g[15:0])  * osel(s3_c[0], fz_reg);
        dsum = 36'(gxo) + 36'(gyo) + 36'(gzo);
        wt_full = 34'(s3_wxy) * 34'(wsel(s3_c[0], dz_reg));
        prod_full = 51'(s4_dot) * $signed({34'd0, s4_wt});
    end

    assign sts.corner_final = (corner_reg == 3'd7);
    assign sts.pipe_empty = !(issue_reg || s1_v || s2_v || s3_v || s4_v || s5_v
                              || fade_pend_reg);

    logic signed [47:0] oct_shift;
    assign oct_shift = $signed(acc_reg) >>> octave_idx;

    logic [47:0] absval;
    assign absval = (cmd.abs_result && oct_acc_reg[47]) ? 48'(-$signed(oct_acc_reg))
                                                         : oct_acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg <= 1'b0;
            s1_v <= 1'b0; s2_v <= 1'b0; s3_v <= 1'b0; s4_v <= 1'b0; s5_v <= 1'b0;
            fade_pend_reg <= 1'b0;
            corner_reg <= '0;
        end
        else
        begin
            fade_pend_reg <= cmd.start_corner;
            if (cmd.start_corner)
                corner_reg <= '0;
            else if (cmd.corner_step)
                corner_reg <= corner_reg + 3'd1;
            issue_reg <= cmd.corner_step;
            s1_v <= cmd.corner_step;
            s2_v <= s1_v;
            s3_v <= s2_v;
            s4_v <= s3_v;
            s5_v <= s4_v;
        end
    end

    logic [47:0] oct_sum;
    assign oct_sum = oct_acc_reg + 48'(oct_shift);

    always_ff @(posedge clk)
    begin
        if (cmd.start_octave)
        begin
            px_reg <= pos_x;
            py_reg <= pos_y;
            pz_reg <= pos_z;
            oct_acc_reg <= '0;
        end
        else if (cmd.octave_done)
        begin
            px_reg <= px_reg << 1;
            py_reg <= py_reg << 1;
            pz_reg <= pz_reg << 1;
            oct_acc_reg <= oct_sum;
        end
        if (cmd.start_corner)
        begin
            ux_reg <= px_reg[F-1:0];
            uy_reg <= py_reg[F-1:0];
            uz_reg <= pz_reg[F-1:0];
            u2x_reg <= 17'((34'(px_reg[F-1:0]) * 34'(px_reg[F-1:0])) >> F);
            u2y_reg <= 17'((34'(py_reg[F-1:0]) * 34'(py_reg[F-1:0])) >> F);
            u2z_reg <= 17'((34'(pz_reg[F-1:0]) * 34'(pz_reg[F-1:0])) >> F);
            fx_reg <= {1'b0, px_reg[F-1:0]};
            fy_reg <= {1'b0, py_reg[F-1:0]};
            fz_reg <= {1'b0, pz_reg[F-1:0]};
            acc_reg <= '0;
        end
        if (fade_pend_reg)
        begin
            dx_reg <= fade_f(ux_reg, u2x_reg);
            dy_reg <= fade_f(uy_reg, u2y_reg);
            dz_reg <= fade_f(uz_reg, u2z_reg);
        end
        s1_c  <= corner_reg;
        s1_hx <= px_mem[cx];
        s1_hy <= py_mem[cy];
        s1_hz <= pz_mem[cz];
        s2_c  <= s1_c;
        s2_h  <= s1_hx ^ s1_hy ^ s1_hz;
        s3_c  <= s2_c;
        s3_g  <= grad_mem[s2_h];
        s3_wxy <= 17'(wxy_full >> F);
        s4_dot <= 34'(dsum >>> 14);
        s4_wt  <= 17'(wt_full >> F);
        s5_prod <= 48'(prod_full >>> F);
        if (s5_v)
            acc_reg <= acc_reg + 48'(s5_prod);
        if (cmd.finish)
        begin
            if ($signed(absval) > $signed(48'sh0000_7FFF_FFFF))
                result <= 32'h7FFF_FFFF;
            else if ($signed(absval) < -$signed(48'sh0000_8000_0000))
                result <= 32'h8000_0000;
            else
                result <= absval[31:0];
        end
    end

endmodule

// File: rtl/gradient_noise_turbulence.sv
// 3d gradient noise with turbulence. load requests (op 0..3) fill the gradient and
// permutation tables back to back while in_stall is low; tables must be written before
// an evaluate reads them. an evaluate request runs each octave as a setup step, eight
// corner issues into a five-stage corner pipeline and a drain; the octaves run one after
// another through the single shared corner pipeline. the next request is accepted only
// once the finish is done and the result has been taken. plain mode runs one octave.
// the result waits in an output register, noise_value is held while stall is high.
module gradient_noise_turbulence
    import gnt_pkg::*;
#(
    parameter int MAX_OCTAVES = 8
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [2:0]         op,
    input  logic [7:0]         entry_index,
    input  logic signed [15:0] grad_x,
    input  logic signed [15:0] grad_y,
    input  logic signed [15:0] grad_z,
    input  logic [7:0]         perm_entry,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] noise_value
);

    logic [3:0] oct_cnt_reg;
    logic       mode_reg;
    logic       out_valid_reg;
    gnt_cmd_t   cmd;
    gnt_sts_t   sts;
    logic [4:0] octave_idx;
    logic [31:0] result;
    logic       accept;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MODE) ? {31'd0, mode_reg} : {28'd0, oct_cnt_reg};
    assign accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oct_cnt_reg   <= 4'd7;
            mode_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr == 3'd0)
                    oct_cnt_reg <= pwdata[3:0];
                else if (paddr == 3'd4)
                    mode_reg <= pwdata[0];
            end
            if (cmd.finish)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign noise_value = result;

    gnt_ctrl #(.MAX_OCTAVES(MAX_OCTAVES)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .op(op), .in_stall(in_stall),
        .out_valid(out_valid_reg), .octave_count(oct_cnt_reg),
        .turbulence_mode(mode_reg), .sts(sts), .cmd(cmd), .octave_idx(octave_idx)
    );

    gnt_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .load_en(accept), .op(op), .entry_index(entry_index),
        .grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .perm_entry(perm_entry),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .cmd(cmd),
        .octave_idx(octave_idx), .sts(sts), .result(result)
    );

endmodule

// File: verif/gradient_noise_turbulence_test.sv
module gradient_noise_turbulence_test;
    import gnt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] OP_RSVD_FIRST = 3'd5;
    localparam logic [2:0] OP_RSVD_MID   = 3'd6;
    localparam logic [2:0] OP_RSVD_LAST  = 3'd7;
    localparam int         OCT_LIMIT     = 8;
    localparam int         TBL_DEPTH     = 256;
    localparam int         FBITS         = 16;
    localparam int         SETTLE_CYCLES = 300;
    localparam int         IDLE_LIMIT    = 20000;
    localparam int         RANDOM_ITEMS  = 800;

    class noise_scoreboard;
        logic signed [15:0] grad_tbl [TBL_DEPTH][3];
        logic [7:0]         perm_x [TBL_DEPTH];
        logic [7:0]         perm_y [TBL_DEPTH];
        logic [7:0]         perm_z [TBL_DEPTH];
        logic [3:0]         octaves;
        logic               turb;
        logic signed [31:0] pending_noise [$];
        int                 mismatches;

        function new();
            octaves = 4'd7;
            turb = 1'b1;
            mismatches = 0;
            for (int i = 0; i < TBL_DEPTH; i++)
            begin
                grad_tbl[i][0] = '0;
                grad_tbl[i][1] = '0;
                grad_tbl[i][2] = '0;
                perm_x[i] = '0;
                perm_y[i] = '0;
                perm_z[i] = '0;
            end
        endfunction

        function longint smooth(longint u);
            longint u2;
            u2 = (u * u) >> FBITS;
            return (u2 * ((3 << FBITS) - 2 * u)) >> FBITS;
        endfunction

        function longint lattice_noise(logic [31:0] p [3]);
            longint fr [3];
            longint fd [3];
            logic [7:0] lat_pt [3];
            longint acc;
            longint wx, wy, wz, wt, ox, oy, oz, dot;
            logic [7:0] h;
            int di, dj, dk;
            acc = 0;
            for (int a = 0; a < 3; a++)
            begin
                fr[a] = longint'(p[a][15:0]);
                lat_pt[a] = p[a][23:16];
                fd[a] = smooth(fr[a]);
            end
            for (int c = 0; c < 8; c++)
            begin
                di = (c >> 2) & 1;
                dj = (c >> 1) & 1;
                dk = c & 1;
                h = perm_x[8'(lat_pt[0] + di)] ^ perm_y[8'(lat_pt[1] + dj)]
                    ^ perm_z[8'(lat_pt[2] + dk)];
                wx = di ? fd[0] : (64'sd1 << FBITS) - fd[0];
                wy = dj ? fd[1] : (64'sd1 << FBITS) - fd[1];
                wz = dk ? fd[2] : (64'sd1 << FBITS) - fd[2];
                wt = (((wx * wy) >> FBITS) * wz) >> FBITS;
                ox = fr[0] - (di ? (64'sd1 << FBITS) : 0);
                oy = fr[1] - (dj ? (64'sd1 << FBITS) : 0);
                oz = fr[2] - (dk ? (64'sd1 << FBITS) : 0);
                dot = longint'(grad_tbl[h][0]) * ox + longint'(grad_tbl[h][1]) * oy
                    + longint'(grad_tbl[h][2]) * oz;
                dot = dot >>> 14;
                acc += (dot * wt) >>> FBITS;
            end
            return acc;
        endfunction

        function void note_request(logic [2:0] opc, logic [7:0] idx,
                                   logic signed [15:0] gx, logic signed [15:0] gy,
                                   logic signed [15:0] gz, logic [7:0] pv,
                                   logic [31:0] px, logic [31:0] py, logic [31:0] pz);
            logic [31:0] p [3];
            longint acc;
            int n;
            case (opc)
                OP_LOAD_GRAD:
                begin
                    grad_tbl[idx][0] = gx;
                    grad_tbl[idx][1] = gy;
                    grad_tbl[idx][2] = gz;
                end
                OP_LOAD_PX: perm_x[idx] = pv;
                OP_LOAD_PY: perm_y[idx] = pv;
                OP_LOAD_PZ: perm_z[idx] = pv;
                OP_EVAL:
                begin
                    p[0] = px;
                    p[1] = py;
                    p[2] = pz;
                    acc = 0;
                    if (turb)
                    begin
                        n = (octaves > OCT_LIMIT) ? OCT_LIMIT : octaves;
                        for (int o = 0; o < n; o++)
                        begin
                            acc += lattice_noise(p) >>> o;
                            for (int a = 0; a < 3; a++)
                                p[a] = p[a] << 1;
                        end
                        if (acc < 0)
                            acc = -acc;
                    end
                    else
                    begin
                        acc = lattice_noise(p);
                    end
                    if (acc > 64'sd2147483647)
                        acc = 64'sd2147483647;
                    if (acc < -64'sd2147483648)
                        acc = -64'sd2147483648;
                    pending_noise.push_back(acc[31:0]);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic signed [31:0] actual);
            logic signed [31:0] want;
            if (pending_noise.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result noise_value=%0d", actual);
                return;
            end
            want = pending_noise.pop_front();
            if (actual !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("noise_value mismatch: expected %0d actual %0d", want, actual);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic psel, penable, pwrite;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_stall;
    logic [2:0] op;
    logic [7:0] entry_index, perm_entry;
    logic signed [15:0] grad_x, grad_y, grad_z;
    logic signed [31:0] pos_x, pos_y, pos_z;
    logic out_valid, out_stall;
    logic signed [31:0] noise_value;

    noise_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;

    gradient_noise_turbulence dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        op = OP_EVAL;
        entry_index = '0;
        grad_x = '0;
        grad_y = '0;
        grad_z = '0;
        perm_entry = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        out_stall = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sb = new();
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(noise_value);
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] opc, logic [7:0] idx,
                                logic signed [15:0] gx, logic signed [15:0] gy,
                                logic signed [15:0] gz, logic [7:0] pv,
                                logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= opc;
        entry_index <= idx;
        grad_x <= gx;
        grad_y <= gy;
        grad_z <= gz;
        perm_entry <= pv;
        pos_x <= px;
        pos_y <= py;
        pos_z <= pz;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_request(opc, idx, gx, gy, gz, pv, px, py, pz);
    endtask

    function automatic logic signed [15:0] rand_grad();
        return 16'($signed($urandom_range(32768)) - 16384);
    endfunction

    task automatic send_load(logic [2:0] opc, logic [7:0] idx);
        send_request(opc, idx, rand_grad(), rand_grad(), rand_grad(),
                     8'($urandom), $urandom, $urandom, $urandom);
    endtask

    task automatic send_eval(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
        send_request(OP_EVAL, 8'($urandom), rand_grad(), rand_grad(), rand_grad(),
                     8'($urandom), px, py, pz);
    endtask

    // wait for all results, then let the block finish any trailing work
    task automatic drain_block();
        in_valid <= 1'b0;
        while (sb.pending_noise.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] reg_idx, logic [31:0] value);
        @(posedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {reg_idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_idx == REG_OCTAVES)
            sb.octaves = value[3:0];
        else
            sb.turb = value[0];
    endtask

    task automatic set_config(logic [3:0] octs, logic mode);
        drain_block();
        write_reg(REG_OCTAVES, {28'd0, octs});
        write_reg(REG_MODE, {31'd0, mode});
    endtask

    function automatic logic [31:0] rand_pos();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(2047)) - 1024) << 12;
            2: return {$urandom_range(1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(511)) - 256) << 16
                            | 32'($urandom_range(65535));
        endcase
    endfunction

    initial
    begin
        int chunk;
        logic [2:0] opc;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b0;
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // fill every table entry before any evaluate
        for (int i = 0; i < TBL_DEPTH; i++)
        begin
            if (i == 0)
                send_request(OP_LOAD_GRAD, 8'(i), 16'sd16384, -16'sd16384, 16'sd16384,
                             8'd0, '0, '0, '0);
            else if (i == 255)
                send_request(OP_LOAD_GRAD, 8'(i), -16'sd16384, 16'sd16384, -16'sd16384,
                             8'd255, '0, '0, '0);
            else
                send_load(OP_LOAD_GRAD, 8'(i));
            send_load(OP_LOAD_PX, 8'(i));
            send_load(OP_LOAD_PY, 8'(i));
            send_load(OP_LOAD_PZ, 8'(i));
        end

        // directed: reset settings, extremes, reserved ops and config
        send_eval(32'h0, 32'h0, 32'h0);
        send_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_eval(32'h0000_FFFF, 32'hFFFF_0001, 32'h00FF_8000);
        send_eval(32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_FFFF);
        send_request(OP_RSVD_FIRST, 8'hFF, 16'sd16384, -16'sd16384, 16'sd0, 8'hFF,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_RSVD_MID, 8'h00, -16'sd1, 16'sd1, 16'sd0, 8'h00, '0, '0, '0);
        send_request(OP_RSVD_LAST, 8'hAA, rand_grad(), rand_grad(), rand_grad(), 8'h55,
                     $urandom, $urandom, $urandom);
        send_request(OP_LOAD_PX, 8'd0, '0, '0, '0, 8'hFF, '0, '0, '0);
        send_eval(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
        set_config(4'd0, 1'b1);
        send_eval(32'h0001_2345, 32'h0002_6789, 32'hFFF3_ABCD);
        set_config(4'd15, 1'b1);
        send_eval(32'h0001_2345, 32'h0002_6789, 32'hFFF3_ABCD);
        send_eval(32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_FFFF);
        set_config(4'd8, 1'b0);
        send_eval(32'h0001_2345, 32'h0002_6789, 32'hFFF3_ABCD);
        send_eval(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        set_config(4'd1, 1'b1);
        send_eval(32'h0001_2345, 32'h0002_6789, 32'hFFF3_ABCD);
        set_config(4'd8, 1'b1);
        send_eval(32'h0001_2345, 32'h0002_6789, 32'hFFF3_ABCD);

        chunk = RANDOM_ITEMS / 6;
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: set_config(4'd15, 1'b0);
                1: set_config(4'd2, 1'b1);
                default: set_config(4'($urandom), 1'($urandom));
            endcase
            if (ph < 2)
            begin
                send_idle_pct = 25;
                recv_stall_pct = 50;
            end
            else if (ph < 4)
            begin
                send_idle_pct = 50;
                recv_stall_pct = 25;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            for (int k = 0; k < chunk; k++)
            begin
                case ($urandom_range(9))
                    0, 1, 2:
                    begin
                        opc = 3'($urandom_range(OP_LOAD_PZ, OP_LOAD_GRAD));
                        send_load(opc, 8'($urandom));
                    end
                    3: send_request(3'($urandom_range(OP_RSVD_LAST, OP_RSVD_FIRST)),
                                    8'($urandom), rand_grad(), rand_grad(), rand_grad(),
                                    8'($urandom), $urandom, $urandom, $urandom);
                    default: send_eval(rand_pos(), rand_pos(), rand_pos());
                endcase
            end
        end

        in_valid <= 1'b0;
        while (sb.pending_noise.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
